// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold in the same cycle.
`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Consequence that must hold in the cycle after the cause.
`define ASSERT_NEXT(lbl, cause, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (conseq)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/aards_pkg.sv =====
// Shared constants, register indexes and helpers of the area-average downscaler.
// No dependencies.
package aards_pkg;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 3;
  localparam int PIX_W         = 8;
  localparam int SRC_W_LIM_DEF = 4096;
  localparam int SRC_H_LIM_DEF = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H = 3'd3;

  // Limit a size register to 1..max
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v, input int max);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (int'(v) > max) r = CFG_W'(max);
    return r;
  endfunction
endpackage

// ===== hw/rtl/area_average_rgb_downscale.sv =====
// Area-average RGB downscaler: top level.
// Uses aards_pkg, aards_ram, aards_div.
//
// Source pixels enter on s_* in raster order; each target pixel leaves on m_*
// as the overlap-weighted mean of the source pixels under it, rounded half up.
// m_tlast marks the final target pixel of a frame; m_tuser flags a bad size
// set-up, given once with zero colour on the final source pixel.
// Sizes are to be written on the cfg channel only while the block is idle;
// the block itself does not enforce this. Every write restarts the frame.
// Per source pixel the block updates up to four accumulator entries (1x1, 1x2,
// 2x1 or 2x2 target pixels touched), each as a read state and a write state
// on the separate read and write ports of the accumulator RAM. A pixel that
// completes a target pixel also runs the 8-step divider and the output load.
// After reset and after each cfg write a clearing pass over all 2*SRC_W_LIM
// entries zeroes the accumulator RAM; s_tready stays low meanwhile.
// One output register parts the sides: new pixels are taken while a result
// waits, but the next result waits in the divider until m_tready frees it.
module area_average_rgb_downscale #(
  parameter int SRC_W_LIM = aards_pkg::SRC_W_LIM_DEF,
  parameter int SRC_H_LIM = aards_pkg::SRC_H_LIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [3*aards_pkg::PIX_W-1:0]    s_tdata,   // red_in, green_in, blue_in
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [3*aards_pkg::PIX_W-1:0]    m_tdata,   // red_out, green_out, blue_out
  output logic                             m_tlast,   // frame_end
  output logic                             m_tuser,   // bad_size
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aards_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aards_pkg::CFG_W-1:0]      cfg_data
);
  import aards_pkg::*;

  localparam int PW     = $clog2(SRC_W_LIM);
  localparam int PH     = $clog2(SRC_H_LIM);
  localparam int AW     = $clog2(SRC_W_LIM + 1);
  localparam int AH     = $clog2(SRC_H_LIM + 1);
  localparam int WT_W   = AW + AH;
  localparam int AREA_W = AW + AH;
  localparam int ACC_W  = PIX_W + PW + PH;
  localparam int DEPTH  = 2 * SRC_W_LIM;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [5:0] {
    ST_CLR  = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_RD   = 6'b000100,
    ST_WR   = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [CFG_W-1:0] fw, fh;
  logic             bad;
  logic [AREA_W-1:0] area;

  // frame position
  logic [PW-1:0]    sx, tx0;
  logic [PH-1:0]    sy, ty0;
  logic [CFG_W-1:0] xrem, yrem;

  // step arithmetic
  logic [CFG_W:0]   s_x, s_y;
  logic             split_x, split_y, full_x, full_y, last_col, last_row;
  logic [AW-1:0]    ox0_c, ox1_c;
  logic [AH-1:0]    oy0_c, oy1_c;
  logic             accept;

  // item being worked on
  logic [PIX_W-1:0]  pix [3];
  logic [PW-1:0]     p_tx0;
  logic              p_ty_par, p_splitx, p_emit, p_last, p_bad;
  logic [AW-1:0]     p_ox0, p_ox1;
  logic [AH-1:0]     p_oy0, p_oy1;
  logic              cx, cy;
  logic [WT_W-1:0]   w;
  logic [ADDR_W-1:0] clr_addr;

  // RAM and divider
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr, acc_addr;
  logic [3*ACC_W-1:0]   ram_wdata, ram_rdata, upd;
  logic                 div_start, div_done;
  logic [3*PIX_W-1:0]   div_q;
  logic                 last_combo, emit_now;

  assign cfg_ready = 1'b1;
  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;

  // size checks
  always_comb begin
    fw  = clamp_size(src_w, SRC_W_LIM);
    fh  = clamp_size(src_h, SRC_H_LIM);
    bad = src_w == '0 || src_h == '0 || dst_w == '0 || dst_h == '0 ||
          int'(src_w) > SRC_W_LIM || int'(src_h) > SRC_H_LIM ||
          dst_w > src_w || dst_h > src_h;
  end

  always_ff @(posedge clk) begin
    area <= AREA_W'(fw) * AREA_W'(fh);
  end

  // overlaps of the current source pixel with its one or two target cells
  always_comb begin
    s_x      = {1'b0, xrem} + {1'b0, dst_w};
    s_y      = {1'b0, yrem} + {1'b0, dst_h};
    split_x  = s_x > {1'b0, fw};
    split_y  = s_y > {1'b0, fh};
    full_x   = s_x >= {1'b0, fw};
    full_y   = s_y >= {1'b0, fh};
    ox0_c    = split_x ? AW'(fw - xrem) : AW'(dst_w);
    oy0_c    = split_y ? AH'(fh - yrem) : AH'(dst_h);
    ox1_c    = AW'(s_x - {1'b0, fw});
    oy1_c    = AH'(s_y - {1'b0, fh});
    last_col = 32'(sx) == 32'(fw) - 32'd1;
    last_row = 32'(sy) == 32'(fh) - 32'd1;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= CFG_W'(1);
      src_h <= CFG_W'(1);
      dst_w <= CFG_W'(1);
      dst_h <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_W: src_w <= cfg_data;
        REG_SRC_H: src_h <= cfg_data;
        REG_DST_W: dst_w <= cfg_data;
        REG_DST_H: dst_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // source and target position tracking
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      sx   <= '0;
      sy   <= '0;
      tx0  <= '0;
      ty0  <= '0;
      xrem <= '0;
      yrem <= '0;
    end else if (accept) begin
      if (last_col) begin
        sx   <= '0;
        tx0  <= '0;
        xrem <= '0;
        if (last_row) begin
          sy   <= '0;
          ty0  <= '0;
          yrem <= '0;
        end else begin
          sy   <= sy + PH'(1);
          ty0  <= ty0 + PH'(full_y);
          yrem <= full_y ? CFG_W'(s_y - {1'b0, fh}) : CFG_W'(s_y);
        end
      end else begin
        sx   <= sx + PW'(1);
        tx0  <= tx0 + PW'(full_x);
        xrem <= full_x ? CFG_W'(s_x - {1'b0, fw}) : CFG_W'(s_x);
      end
    end
  end

  // latch the accepted pixel and what it touches
  always_ff @(posedge clk) begin
    if (accept) begin
      pix[0]   <= s_tdata[0 +: PIX_W];
      pix[1]   <= s_tdata[PIX_W +: PIX_W];
      pix[2]   <= s_tdata[2*PIX_W +: PIX_W];
      p_tx0    <= tx0;
      p_ty_par <= ty0[0];
      p_splitx <= split_x;
      p_emit   <= full_x && full_y;
      p_last   <= 32'(tx0) == 32'(dst_w) - 32'd1 && 32'(ty0) == 32'(dst_h) - 32'd1;
      p_ox0    <= ox0_c;
      p_ox1    <= ox1_c;
      p_oy0    <= oy0_c;
      p_oy1    <= oy1_c;
      p_bad    <= bad;
    end
  end

  // accumulator address and weight of the current cell
  assign acc_addr   = {p_ty_par ^ cy, PW'(p_tx0 + PW'(cx))};
  assign last_combo = !cx && !cy;
  assign emit_now   = state == ST_WR && last_combo && p_emit;

  always_ff @(posedge clk) begin
    if (state == ST_RD) begin
      w <= WT_W'(cy ? p_oy1 : p_oy0) * WT_W'(cx ? p_ox1 : p_ox0);
    end
  end

  // read-modify-write of one accumulator entry
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      upd[c*ACC_W +: ACC_W] = ram_rdata[c*ACC_W +: ACC_W] + ACC_W'(pix[c]) * ACC_W'(w);
    end
    ram_raddr = acc_addr;
    ram_we    = state == ST_CLR || state == ST_WR;
    ram_waddr = state == ST_CLR ? clr_addr : acc_addr;
    ram_wdata = (state == ST_CLR || emit_now) ? '0 : upd;
  end

  assign div_start = emit_now;

  aards_ram #(
    .WIDTH (3 * ACC_W),
    .DEPTH (DEPTH)
  ) u_acc (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aards_div #(
    .ACC_W  (ACC_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sums  (upd),
    .area  (area),
    .done  (div_done),
    .quot  (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst || cfg_valid) begin
      state    <= ST_CLR;
      clr_addr <= '0;
      cx       <= 1'b0;
      cy       <= 1'b0;
    end else begin
      case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            cx <= split_x;
            cy <= split_y;
            if (bad) begin
              if (last_col && last_row) state <= ST_OUT;
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          if (last_combo) begin
            state <= p_emit ? ST_DIV : ST_IDLE;
          end else begin
            state <= ST_RD;
            if (cx) begin
              cx <= 1'b0;
            end else begin
              cx <= p_splitx;
              cy <= 1'b0;
            end
          end
        end
        ST_DIV: if (div_done) state <= ST_OUT;
        ST_OUT: if (!m_tvalid || m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= p_bad ? '0 : div_q;
      m_tlast <= p_bad || p_last;
      m_tuser <= p_bad;
    end
  end
endmodule

// ===== hw/rtl/aards_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module aards_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/aards_div.sv =====
// Restoring divider: three channels of (2*sum + area) / (2*area), one quotient bit a cycle.
// Uses aards_pkg.
module aards_div #(
  parameter int ACC_W  = 32,
  parameter int AREA_W = 26
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [3*ACC_W-1:0]           sums,
  input  logic [AREA_W-1:0]            area,
  output logic                         done,
  output logic [3*aards_pkg::PIX_W-1:0] quot
);
  import aards_pkg::*;

  localparam int DW = ACC_W + AREA_W + 10;

  logic [DW-1:0]    rem [3];
  logic [DW-1:0]    dsh;
  logic [PIX_W-1:0] q   [3];
  logic [2:0]       sat;
  logic [2:0]       cnt;
  logic             busy;
  logic [DW-1:0]    num [3];
  logic [DW-1:0]    den8;

  // numerators and the full-scale divisor at start
  always_comb begin
    den8 = DW'(area) << 9;
    for (int c = 0; c < 3; c++) begin
      num[c] = (DW'(sums[c*ACC_W +: ACC_W]) << 1) + DW'(area);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd7;
      end else if (busy) begin
        cnt <= cnt - 3'd1;
        if (cnt == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dsh <= DW'(area) << 8;
      for (int c = 0; c < 3; c++) begin
        rem[c] <= num[c];
        q[c]   <= '0;
        sat[c] <= num[c] >= den8;
      end
    end else if (busy) begin
      dsh <= dsh >> 1;
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= dsh) begin
          rem[c] <= rem[c] - dsh;
          q[c]   <= {q[c][PIX_W-2:0], 1'b1};
        end else begin
          q[c] <= {q[c][PIX_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot[c*PIX_W +: PIX_W] = sat[c] ? {PIX_W{1'b1}} : q[c];
    end
  end
endmodule

// ===== hw/rtl/aards_chk.sv =====
// Port-level checker for the area-average downscaler, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"
module aards_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  // a bad-size result carries no colour and closes the frame
  `ASSERT_HOLDS(a_bad_blank, m_tvalid && m_tuser |-> m_tdata == 24'd0)
  `ASSERT_HOLDS(a_bad_last, m_tvalid && m_tuser |-> m_tlast)
  // a size write starts the clearing pass
  `ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, !s_tready)
  // stalled result holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind area_average_rgb_downscale aards_chk u_chk (.*);
